FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, masked while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/cnllc_pkg.sv
// ----------------------------------------------------------------------------
// cnllc_pkg
// types, codes and digit arithmetic shared by the card number checker
// ----------------------------------------------------------------------------
package cnllc_pkg;

  localparam int DIGIT_W = 4;
  localparam int CAT_W   = 3;
  localparam int COUNT_W = 5;
  localparam int SUM_W   = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // category codes
  localparam logic [CAT_W-1:0] CAT_INVALID   = 3'd0;
  localparam logic [CAT_W-1:0] CAT_RANGE_A   = 3'd1;
  localparam logic [CAT_W-1:0] CAT_FIXED_15  = 3'd2;
  localparam logic [CAT_W-1:0] CAT_RANGE_B   = 3'd3;
  localparam logic [CAT_W-1:0] CAT_FIXED_16A = 3'd4;
  localparam logic [CAT_W-1:0] CAT_FIXED_19  = 3'd5;
  localparam logic [CAT_W-1:0] CAT_FIXED_16B = 3'd6;
  localparam logic [CAT_W-1:0] CAT_WIDE      = 3'd7;

  // allowed lengths
  localparam logic [COUNT_W-1:0] LEN_12 = 5'd12;
  localparam logic [COUNT_W-1:0] LEN_13 = 5'd13;
  localparam logic [COUNT_W-1:0] LEN_15 = 5'd15;
  localparam logic [COUNT_W-1:0] LEN_16 = 5'd16;
  localparam logic [COUNT_W-1:0] LEN_19 = 5'd19;

  typedef enum logic [1:0] {
    STATUS_VALID      = 2'd0,
    STATUS_BAD_LENGTH = 2'd1,
    STATUS_BAD_LUHN   = 2'd2
  } status_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum_even;  // even positions from the left doubled
    logic [SUM_W-1:0]   sum_odd;   // odd positions from the left doubled
  } luhn_state_t;

  // digit taken mod 10
  function automatic logic [SUM_W-1:0] plain_part(input logic [DIGIT_W-1:0] d);
    if (d >= 4'd10) begin
      return d - 4'd10;
    end
    return d;
  endfunction

  // doubled digit, minus nine above nine, then mod 10
  function automatic logic [SUM_W-1:0] doubled_part(input logic [DIGIT_W-1:0] d);
    logic [DIGIT_W:0] t;
    t = {d, 1'b0};
    if (t > 5'd9) begin
      t = t - 5'd9;
    end
    if (t >= 5'd20) begin
      t = t - 5'd20;
    end else if (t >= 5'd10) begin
      t = t - 5'd10;
    end
    return t[SUM_W-1:0];
  endfunction

  // sum of two values below ten, mod 10
  function automatic logic [SUM_W-1:0] add_mod10(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 5'd10) begin
      s = s - 5'd10;
    end
    return s[SUM_W-1:0];
  endfunction

  function automatic logic length_ok(input logic [CAT_W-1:0]   cat,
                                     input logic [COUNT_W-1:0] n);
    logic ok;
    unique case (cat) inside
      CAT_RANGE_A, CAT_RANGE_B:     ok = (n >= LEN_13) && (n <= LEN_16);
      CAT_FIXED_15:                 ok = (n == LEN_15);
      CAT_FIXED_16A, CAT_FIXED_16B: ok = (n == LEN_16);
      CAT_FIXED_19:                 ok = (n == LEN_19);
      CAT_WIDE:                     ok = (n >= LEN_12) && (n <= LEN_19);
      default:                      ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: hdl/cnllc_step.sv
// ----------------------------------------------------------------------------
// cnllc_step
// one digit of the running luhn sums, digit count and final status
// ----------------------------------------------------------------------------
module cnllc_step (
  input  cnllc_pkg::luhn_state_t              state_cur,
  input  logic [cnllc_pkg::DIGIT_W-1:0]       digit,
  input  logic [cnllc_pkg::CAT_W-1:0]         category,
  input  logic                                last_digit,
  output cnllc_pkg::luhn_state_t              state_nxt,
  output cnllc_pkg::status_t                  status
);

  logic [cnllc_pkg::SUM_W-1:0]   p;
  logic [cnllc_pkg::SUM_W-1:0]   q;
  logic                          even_pos;
  cnllc_pkg::luhn_state_t        upd;
  logic [cnllc_pkg::SUM_W-1:0]   luhn;

  assign p        = cnllc_pkg::plain_part(digit);
  assign q        = cnllc_pkg::doubled_part(digit);
  assign even_pos = ~state_cur.count[0];

  always_comb begin
    upd.sum_even = cnllc_pkg::add_mod10(state_cur.sum_even, even_pos ? q : p);
    upd.sum_odd  = cnllc_pkg::add_mod10(state_cur.sum_odd,  even_pos ? p : q);
    upd.count    = (state_cur.count < cnllc_pkg::COUNT_MAX) ?
                   state_cur.count + 5'd1 : state_cur.count;
  end

  // rightmost digit undoubled: parity of the length picks the sum
  assign luhn = upd.count[0] ? upd.sum_odd : upd.sum_even;

  always_comb begin
    if (!cnllc_pkg::length_ok(category, upd.count)) begin
      status = cnllc_pkg::STATUS_BAD_LENGTH;
    end else if (luhn != '0) begin
      status = cnllc_pkg::STATUS_BAD_LUHN;
    end else begin
      status = cnllc_pkg::STATUS_VALID;
    end
  end

  // a finished number leaves clean state for the next one
  assign state_nxt = last_digit ? '0 : upd;

endmodule

FILE: hdl/card_number_luhn_length_check.sv
// ----------------------------------------------------------------------------
// card_number_luhn_length_check
// Card number length and Luhn check digit test, one decimal digit per item,
// most significant digit first. Each input item carries a digit, the card
// category and tlast on the final digit of the number. The block keeps a
// digit count that saturates at 31 and two Luhn sums mod 10, and on the last
// digit returns one status item: 0 valid, 1 bad length or category (checked
// first), 2 Luhn sum not zero. Items without tlast give no result. Category 0
// is always bad; categories 1 and 3 allow 13 to 16 digits, 2 needs 15, 4 and
// 6 need 16, 5 needs 19, 7 allows 12 to 19. The Luhn rule treats the
// rightmost digit as undoubled, so any length is handled correctly. Digits
// above nine are taken mod 10 (plain) or doubled, reduced by nine, then
// taken mod 10. Throughput is one item per clock, save for the stall below:
// an input register feeds a single level of mod-10 adders and compares
// into the result register, which drives the status of a last digit on
// out_tdata. Only a last-digit item held behind an undelivered result
// waits; others pass.
// ----------------------------------------------------------------------------
module card_number_luhn_length_check (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [3:0] digit, [6:4] category, [7] zero
  input  logic       in_tlast,   // last_digit
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [1:0] status, [7:2] zero
);

  // input register
  logic                            in_valid_r;
  logic [cnllc_pkg::DIGIT_W-1:0]   in_digit_r;
  logic [cnllc_pkg::CAT_W-1:0]     in_cat_r;
  logic                            in_last_r;

  // running per-number state
  cnllc_pkg::luhn_state_t          state_r;
  cnllc_pkg::luhn_state_t          state_nxt;

  // result register
  logic                            out_valid_r;
  cnllc_pkg::status_t              out_status_r;
  cnllc_pkg::status_t              status_nxt;

  logic                            advance;
  logic                            in_fire;

  // the held item moves on unless it makes a result and the result slot is
  // still occupied by one that nobody has taken
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  cnllc_step u_step (
    .state_cur  (state_r),
    .digit      (in_digit_r),
    .category   (in_cat_r),
    .last_digit (in_last_r),
    .state_nxt  (state_nxt),
    .status     (status_nxt)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_fire) begin
      in_valid_r <= 1'b1;
    end else if (advance) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_digit_r <= in_tdata[3:0];
      in_cat_r   <= in_tdata[6:4];
      in_last_r  <= in_tlast;
    end
  end

  // count and sums move with every digit that leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_status_r <= status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_status_r};

endmodule

FILE: hdl/cnllc_checker.sv
// ----------------------------------------------------------------------------
// cnllc_checker
// port-level checks on the card number checker, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cnllc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [7:0] in_tdata,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // no result survives reset
  `ASSERT_CLK_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid,
                     "result valid after reset")

  // a stalled result keeps its value
  `ASSERT_CLK(a_out_hold, clk, rst_n,
              out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
              "stalled result changed")

  // only defined status codes, padding bits zero
  `ASSERT_CLK(a_status_code, clk, rst_n,
              out_tvalid |-> (out_tdata[1:0] != 2'd3) && (out_tdata[7:2] == 6'd0),
              "bad status encoding")

  // with no result pending the input side never stalls
  `ASSERT_CLK(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready,
              "input stalled with empty result slot")

  // an offered item waits unchanged until it is taken
  `ASSERT_CLK(a_in_hold, clk, rst_n,
              in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tlast),
              "waiting input item changed")

endmodule

bind card_number_luhn_length_check cnllc_checker u_cnllc_checker (.*);
